FILE: src/ypld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ypld_pkg : shared types and constants for the yaw/pitch look-direction unit
// Beat formats, sequencer states, CORDIC constants and the arctangent table.
// ============================================================================
package ypld_pkg;

  // Default angle resolution: 2^ANGLE_BITS units per turn
  localparam int ANGLE_BITS_DEF = 16;
  // Result component width, signed Q1.(OUT_BITS-1)
  localparam int OUT_BITS       = 16;
  // Width of the input increments and of the pitch limit register port
  localparam int IN_W           = 16;
  localparam int PLIM_W         = 15;

  // CORDIC: 30 rotations, working values at 2^30 scale, angle in 2^-32 turn
  localparam int CORDIC_STEPS  = 30;
  localparam int CORDIC_W      = 32;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 32'sh26DD3B6A;

  typedef struct packed {
    logic signed [IN_W-1:0] yaw_change;
    logic signed [IN_W-1:0] pitch_change;
  } ypld_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] dir_x;
    logic signed [OUT_BITS-1:0] dir_y;
    logic signed [OUT_BITS-1:0] dir_z;
  } ypld_out_t;

  // Cosine and sine from one rotator, 2^30 scale
  typedef struct packed {
    logic signed [CORDIC_W-1:0] cos_v;
    logic signed [CORDIC_W-1:0] sin_v;
  } ypld_sc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDP,
    ST_UPD,
    ST_ROT,
    ST_MX,
    ST_MZ,
    ST_RZ,
    ST_OUTP
  } ypld_state_t;

  // Quarter turn less 0.001 rad, in angle units
  function automatic int plim_reset(input int ab);
    longint margin;
    margin = ((longint'(1) << ab) * 64'd159155) / 64'd1000000000;
    return int'((longint'(1) << (ab - 2)) - margin);
  endfunction

  // atan(2^-i) in units of 2^-32 turn, rounded to the nearest unit
  function automatic logic [CORDIC_W-1:0] atan_turn(input logic [4:0] i);
    logic [CORDIC_W-1:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/ypld_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ypld_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module ypld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/ypld_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ypld_cordic : iterative rotation-mode CORDIC, one step per cycle
// Folds the angle into +/- a quarter turn, runs 30 rotations, then applies
// the fold sign. Gives cosine and sine at 2^30 scale.
// ============================================================================
module ypld_cordic
  import ypld_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output      logic                  done,
  output      ypld_sc_t              res
);

  localparam logic [4:0] LAST = 5'(CORDIC_STEPS);

  logic signed [ANGLE_BITS:0] qtr_s;
  logic signed [ANGLE_BITS:0] half_s;
  logic signed [ANGLE_BITS:0] a_w;
  logic signed [ANGLE_BITS:0] a_f;
  logic                       fold_neg;
  logic signed [CORDIC_W-1:0] z0;

  logic                       run_r;
  logic [4:0]                 step_r;
  logic                       done_r;
  logic                       neg_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic signed [CORDIC_W-1:0] shx, shy, x_nxt, y_nxt, z_nxt, at;

  assign qtr_s  = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 2);
  assign half_s = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);

  // Fold into [-quarter, +quarter]; the upper half of the unsigned range is negative
  always_comb begin
    a_w      = $signed({angle[ANGLE_BITS-1], angle});
    a_f      = a_w;
    fold_neg = 1'b0;
    if (a_w > qtr_s) begin
      a_f      = a_w - half_s;
      fold_neg = 1'b1;
    end else if (a_w < -qtr_s) begin
      a_f      = a_w + half_s;
      fold_neg = 1'b1;
    end
    z0 = $signed({a_f[ANGLE_BITS-1:0], {(CORDIC_W-ANGLE_BITS){1'b0}}});
  end

  always_comb begin
    shx = x_r >>> step_r;
    shy = y_r >>> step_r;
    at  = $signed(atan_turn(step_r));
    if (z_r >= 0) begin
      x_nxt = x_r - shy;
      y_nxt = y_r + shx;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + shy;
      y_nxt = y_r - shx;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_K;
      y_r   <= '0;
      z_r   <= z0;
      neg_r <= fold_neg;
    end else if (run_r) begin
      if (step_r == LAST) begin
        // undo the half-turn fold
        if (neg_r) begin
          x_r <= -x_r;
          y_r <= -y_r;
        end
      end else begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
      end
    end
  end

  assign done      = done_r;
  assign res.cos_v = x_r;
  assign res.sin_v = y_r;

endmodule
`default_nettype wire

FILE: src/yaw_pitch_look_direction.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// yaw_pitch_look_direction : camera look vector from yaw and pitch deltas
// Accumulates yaw (wrapping) and pitch (clamped), then returns the unit
// direction vector from two iterative CORDIC rotators.
// ============================================================================
//
//  Channel | Ports                          | Beat
//  --------+--------------------------------+--------------------------------
//  input   | in_valid, in_ready, in_data    | yaw_change, pitch_change (s16)
//  result  | out_valid, out_ready, out_data | dir_x, dir_y, dir_z (Q1.15)
//  config  | cfg_we, cfg_wdata              | pitch_limit (u15), no wait
//
//  One beat in gives one beat out. Each item is finished before the next
//  is accepted: the read-modify-write of the angle store, the 30-step
//  CORDIC loop (one rotation per cycle, both angles in parallel) and two
//  passes through the one shared multiplier.
//  Reset clears control state and the store's valid bits, so yaw and pitch
//  read as zero until first written; no clearing pass is needed.
//  The result sits in an output register, so the sequencer is free to take
//  a new beat while a result waits; it stalls only when the next result is
//  ready and the previous one has not been taken.
//
//  Yaw and pitch live in a two-entry RAM (yaw at 0, pitch at 1). Each item
//  reads yaw, then pitch, and writes each back as soon as it is updated;
//  items are processed one at a time so no forwarding is required.
//
module yaw_pitch_look_direction
  import ypld_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire ypld_in_t          in_data,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      ypld_out_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [PLIM_W-1:0] cfg_wdata
);

  // Widths for the accumulator arithmetic
  localparam int YS_W  = (ANGLE_BITS > IN_W) ? ANGLE_BITS : IN_W;
  localparam int PS_W  = YS_W + 1;
  localparam int LIM_W = (ANGLE_BITS - 1 > PLIM_W) ? ANGLE_BITS - 1 : PLIM_W;
  localparam logic [LIM_W-1:0] PLIM_RST = LIM_W'(plim_reset(ANGLE_BITS));
  localparam logic [LIM_W-1:0] QTR      = LIM_W'(1) << (ANGLE_BITS - 2);

  localparam logic       ADDR_YAW   = 1'b0;
  localparam logic       ADDR_PITCH = 1'b1;

  // Output rounding and saturation
  localparam int OUT_SH = 31 - OUT_BITS;
  localparam logic signed [34:0] RND_HALF = 35'sd1 <<< (OUT_SH - 1);
  localparam logic signed [34:0] OUT_HI   = (35'sd1 <<< (OUT_BITS - 1)) - 35'sd1;
  localparam logic signed [34:0] OUT_LO   = -(35'sd1 <<< (OUT_BITS - 1));
  localparam logic signed [63:0] RND30    = 64'sd1 <<< 29;

  function automatic logic signed [OUT_BITS-1:0] to_out(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [34:0] r;
    t = 35'(v) + RND_HALF;
    r = t >>> OUT_SH;
    if (r > OUT_HI) begin
      r = OUT_HI;
    end
    if (r < OUT_LO) begin
      r = OUT_LO;
    end
    return r[OUT_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  ypld_state_t state_r, state_nxt;
  logic [LIM_W-1:0]        pitch_limit_r;
  logic [1:0]              valid_r;
  ypld_in_t                in_r;
  logic [ANGLE_BITS-1:0]   yaw_new_r;
  logic signed [63:0]      prod_r;
  logic signed [33:0]      dx_r, dz_r;
  ypld_out_t               out_data_r;
  logic                    out_valid_r;

  // --------------------------------------------------------------------------
  // Sequencer controls
  // --------------------------------------------------------------------------
  logic                    mem_re, mem_we;
  logic                    mem_raddr, mem_waddr;
  logic [ANGLE_BITS-1:0]   mem_wdata, mem_rdata;
  logic                    cordic_start;
  logic                    ld_yaw, ld_mx, ld_mz, ld_rz, ld_out;
  logic                    out_free;
  logic                    cordic_done, done_yaw, done_pitch;
  ypld_sc_t                yaw_sc, pitch_sc;

  // --------------------------------------------------------------------------
  // Accumulator update
  // --------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0]   yaw_cur, yaw_new;
  logic [YS_W-1:0]         yaw_sum;
  logic signed [ANGLE_BITS-1:0] pitch_cur;
  logic signed [PS_W-1:0]  p_sum, p_clamp, lim_s;
  logic [LIM_W-1:0]        lim_eff;
  logic [ANGLE_BITS-1:0]   pitch_new;
  logic signed [63:0]      prod_rnd;

  // entries never written read as zero
  assign yaw_cur   = valid_r[ADDR_YAW]   ? mem_rdata : '0;
  assign pitch_cur = valid_r[ADDR_PITCH] ? $signed(mem_rdata) : '0;

  assign yaw_sum = YS_W'(yaw_cur) + YS_W'(in_r.yaw_change);
  assign yaw_new = yaw_sum[ANGLE_BITS-1:0];

  always_comb begin
    lim_eff = (pitch_limit_r > QTR) ? QTR : pitch_limit_r;
    lim_s   = $signed(PS_W'(lim_eff));
    p_sum   = PS_W'(pitch_cur) + PS_W'(in_r.pitch_change);
    p_clamp = p_sum;
    if (p_sum > lim_s) begin
      p_clamp = lim_s;
    end
    if (p_sum < -lim_s) begin
      p_clamp = -lim_s;
    end
  end

  assign pitch_new = p_clamp[ANGLE_BITS-1:0];
  assign prod_rnd  = prod_r + RND30;

  assign out_free    = !out_valid_r || out_ready;
  assign cordic_done = done_yaw && done_pitch;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RDP;
        end
      end
      ST_RDP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_ROT;
      ST_ROT: begin
        if (cordic_done) begin
          state_nxt = ST_MX;
        end
      end
      ST_MX:   state_nxt = ST_MZ;
      ST_MZ:   state_nxt = ST_RZ;
      ST_RZ:   state_nxt = ST_OUTP;
      ST_OUTP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ADDR_YAW;
    mem_we       = 1'b0;
    mem_waddr    = ADDR_YAW;
    mem_wdata    = yaw_new;
    cordic_start = 1'b0;
    ld_yaw       = 1'b0;
    ld_mx        = 1'b0;
    ld_mz        = 1'b0;
    ld_rz        = 1'b0;
    ld_out       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_re    = in_valid;
        mem_raddr = ADDR_YAW;
      end
      ST_RDP: begin
        // yaw data back: update and write; fetch pitch
        mem_re    = 1'b1;
        mem_raddr = ADDR_PITCH;
        mem_we    = 1'b1;
        mem_waddr = ADDR_YAW;
        mem_wdata = yaw_new;
        ld_yaw    = 1'b1;
      end
      ST_UPD: begin
        mem_we       = 1'b1;
        mem_waddr    = ADDR_PITCH;
        mem_wdata    = pitch_new;
        cordic_start = 1'b1;
      end
      ST_ROT:  ld_mx  = cordic_done;
      ST_MX:   ld_mz  = 1'b1;
      ST_MZ:   ld_rz  = 1'b1;
      ST_RZ:   ld_out = 1'b0;
      ST_OUTP: ld_out = out_free;
      default: ld_out = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pitch_limit_r <= PLIM_RST;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        pitch_limit_r <= LIM_W'(cfg_wdata);
      end
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (ld_yaw) begin
      yaw_new_r <= yaw_new;
    end
    // one multiplier, two passes: x then z
    if (ld_mx) begin
      prod_r <= pitch_sc.cos_v * yaw_sc.sin_v;
    end
    if (ld_mz) begin
      dx_r   <= prod_rnd[63:30];
      prod_r <= pitch_sc.cos_v * yaw_sc.cos_v;
    end
    if (ld_rz) begin
      dz_r <= prod_rnd[63:30];
    end
    if (ld_out) begin
      out_data_r.dir_x <= to_out(dx_r);
      out_data_r.dir_y <= to_out(34'(pitch_sc.sin_v));
      out_data_r.dir_z <= to_out(dz_r);
    end
  end

  // --------------------------------------------------------------------------
  // Angle store and rotators
  // --------------------------------------------------------------------------
  ypld_ram #(
    .WIDTH (ANGLE_BITS),
    .DEPTH (2)
  ) u_angle_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ypld_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic_yaw (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (yaw_new_r),
    .done  (done_yaw),
    .res   (yaw_sc)
  );

  ypld_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (pitch_new),
    .done  (done_pitch),
    .res   (pitch_sc)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
